### sv/svf_coefficient_calculator_unit_macros.svh
// Assertion macros shared by the coefficient calculator modules.
// Expects clk and rst_n in the scope of each use.
`ifndef SVF_COEFFICIENT_CALCULATOR_UNIT_MACROS_SVH
`define SVF_COEFFICIENT_CALCULATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SVFCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SVFCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/svfcc_pkg.sv
// Shared types and constants of the SVF coefficient calculator.
// No dependencies; imported by the interfaces and all modules but svfcc_ram.
package svfcc_pkg;

  // Field widths of the channels
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 24;
  localparam int COEF_W  = 17;
  localparam int DAMP_W  = 18;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD_GAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_DAMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE   = 2'd2;

  // Arithmetic sizing
  localparam int FRAC_W     = 16;               // Q16
  localparam int MUL_A_W    = 32;               // gain operand, widest gain
  localparam int DIGIT_W    = 16;               // multiplier digit per cycle
  localparam int MUL_DIGITS = 3;
  localparam int MUL_B_W    = DIGIT_W * MUL_DIGITS;
  localparam int HI_W       = MUL_A_W + 1;      // running upper partial sum
  localparam int SUM_W      = MUL_B_W + 1;
  localparam int DEN_W      = 50;               // 65536 + (g*(g+k) >> 16)
  localparam int DIV_STEPS  = COEF_W;           // quotient bits of 2^32 / den
  localparam int CNT_W      = 5;

  localparam logic [COEF_W-1:0] Q16_ONE       = 17'd65536;
  localparam logic [DAMP_W-1:0] PASS_DAMPING  = 18'd131072;
  localparam logic [DEN_W-1:0]  DEN_OFFSET    = 50'd65536;
  // 2^32 >> 17: first partial remainder, always below den
  localparam logic [DEN_W-1:0]  DIV_REM_INIT  = 50'd32768;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PASS,
    OP_LATCH,
    OP_MUL,
    OP_DIV_SET,
    OP_DIV,
    OP_MUL2_SET,
    OP_MUL3_SET,
    OP_OUT
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   we_gain;
    logic   we_damp;
    logic   rd_en;
  } svfcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;
  } svfcc_sts_t;

endpackage

### sv/svfcc_in_if.sv
// Input channel of the coefficient calculator: valid/ready plus item fields.
// Depends on svfcc_pkg for field widths.
interface svfcc_in_if import svfcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  entry_index;
  logic [VAL_W-1:0]  entry_value;
  logic [IDX_W-1:0]  cutoff_index;
  logic [IDX_W-1:0]  resonance_index;

  modport source (output valid, mode, entry_index, entry_value, cutoff_index,
                  resonance_index, input ready);
  modport sink   (input valid, mode, entry_index, entry_value, cutoff_index,
                  resonance_index, output ready);
endinterface

### sv/svfcc_out_if.sv
// Result channel of the coefficient calculator: valid/ready plus coefficients.
// Depends on svfcc_pkg for field widths.
interface svfcc_out_if import svfcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coeff_a1;
  logic [COEF_W-1:0] coeff_a2;
  logic [COEF_W-1:0] coeff_a3;
  logic [DAMP_W-1:0] damping_out;

  modport source (output valid, coeff_a1, coeff_a2, coeff_a3, damping_out,
                  input ready);
  modport sink   (input valid, coeff_a1, coeff_a2, coeff_a3, damping_out,
                  output ready);
endinterface

### sv/svfcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module svfcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/svfcc_dp.sv
// Datapath: coefficient tables, 32x16 digit multiplier, restoring divider,
// output register. Depends on svfcc_pkg, svfcc_ram and the macros header.
`include "svf_coefficient_calculator_unit_macros.svh"

module svfcc_dp import svfcc_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int GAIN_WIDTH  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  svfcc_cmd_t        cmd,
  output svfcc_sts_t        sts,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [VAL_W-1:0]  entry_value,
  input  logic [IDX_W-1:0]  cutoff_index,
  input  logic [IDX_W-1:0]  resonance_index,
  output logic [COEF_W-1:0] coeff_a1,
  output logic [COEF_W-1:0] coeff_a2,
  output logic [COEF_W-1:0] coeff_a3,
  output logic [DAMP_W-1:0] damping_out
);

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam int MIN_DEPTH  = 16;
  localparam int WRAP_STEPS = IDX_W - $clog2(MIN_DEPTH);
  localparam int WRAP_W     = 16;

  // Index modulo table depth: a few compare/subtract steps on 8-bit values
  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
    logic [WRAP_W-1:0] v;
    v = WRAP_W'(idx);
    for (int j = WRAP_STEPS - 1; j >= 0; j--) begin
      if (v >= (WRAP_W'(TABLE_DEPTH) << j)) begin
        v = v - (WRAP_W'(TABLE_DEPTH) << j);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [GAIN_WIDTH-1:0] gain_rdata;
  logic [DAMP_W-1:0]     damp_rdata;
  logic [AW-1:0]         waddr;

  assign waddr = wrap_idx(entry_index);

  // Coefficient tables
  svfcc_ram #(.WIDTH(GAIN_WIDTH), .DEPTH(TABLE_DEPTH)) u_gain_ram (
    .clk   (clk),
    .we    (cmd.we_gain),
    .waddr (waddr),
    .wdata (GAIN_WIDTH'(entry_value)),
    .re    (cmd.rd_en),
    .raddr (wrap_idx(cutoff_index)),
    .rdata (gain_rdata)
  );

  svfcc_ram #(.WIDTH(DAMP_W), .DEPTH(TABLE_DEPTH)) u_damp_ram (
    .clk   (clk),
    .we    (cmd.we_damp),
    .waddr (waddr),
    .wdata (entry_value[DAMP_W-1:0]),
    .re    (cmd.rd_en),
    .raddr (wrap_idx(resonance_index)),
    .rdata (damp_rdata)
  );

  logic [MUL_A_W-1:0] g_r, g_nxt;
  logic [DAMP_W-1:0]  k_r, k_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;
  logic [HI_W-1:0]    hi_r, hi_nxt;
  logic [MUL_B_W-1:0] lo_r, lo_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [COEF_W-1:0]  q_r, q_nxt;
  logic [COEF_W-1:0]  a2_r, a2_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pass_r, pass_nxt;
  logic [COEF_W-1:0]  a1_out_r, a1_out_nxt;
  logic [COEF_W-1:0]  a2_out_r, a2_out_nxt;
  logic [COEF_W-1:0]  a3_out_r, a3_out_nxt;
  logic [DAMP_W-1:0]  damp_out_r, damp_out_nxt;

  logic [MUL_B_W-1:0] pp;
  logic [SUM_W-1:0]   sum;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W+1:0]   diff;

  // One 32x16 partial product per cycle, low digit first
  assign pp  = g_r * b_r[DIGIT_W-1:0];
  assign sum = SUM_W'(hi_r) + SUM_W'(pp);

  // Restoring divide step
  assign rem_sh = {rem_r, 1'b0};
  assign diff   = (DEN_W+2)'(rem_sh) - (DEN_W+2)'(den_r);

  always_comb begin
    g_nxt        = g_r;
    k_nxt        = k_r;
    b_nxt        = b_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    a2_nxt       = a2_r;
    cnt_nxt      = cnt_r;
    pass_nxt     = pass_r;
    a1_out_nxt   = a1_out_r;
    a2_out_nxt   = a2_out_r;
    a3_out_nxt   = a3_out_r;
    damp_out_nxt = damp_out_r;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_PASS: begin
        pass_nxt = 1'b1;
      end
      OP_LATCH: begin
        // g, k from the tables; first product is g*(g+k)
        g_nxt    = MUL_A_W'(gain_rdata);
        k_nxt    = damp_rdata;
        b_nxt    = MUL_B_W'(gain_rdata) + MUL_B_W'(damp_rdata);
        hi_nxt   = '0;
        cnt_nxt  = CNT_W'(MUL_DIGITS - 1);
        pass_nxt = 1'b0;
      end
      OP_MUL: begin
        hi_nxt  = sum[SUM_W-1:DIGIT_W];
        lo_nxt  = {sum[DIGIT_W-1:0], lo_r[MUL_B_W-1:DIGIT_W]};
        b_nxt   = {{DIGIT_W{1'b0}}, b_r[MUL_B_W-1:DIGIT_W]};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_DIV_SET: begin
        // den = 65536 + (g*(g+k) >> 16)
        den_nxt = DEN_OFFSET +
                  DEN_W'({hi_r[DEN_W-1-(MUL_B_W-FRAC_W)-1:0], lo_r[MUL_B_W-1:FRAC_W]});
        rem_nxt = DIV_REM_INIT;
        q_nxt   = '0;
        cnt_nxt = CNT_W'(DIV_STEPS - 1);
      end
      OP_DIV: begin
        if (!diff[DEN_W+1]) begin
          rem_nxt = diff[DEN_W-1:0];
          q_nxt   = {q_r[COEF_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          q_nxt   = {q_r[COEF_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_MUL2_SET: begin
        // g * a1
        b_nxt   = MUL_B_W'(q_r);
        hi_nxt  = '0;
        cnt_nxt = CNT_W'(MUL_DIGITS - 1);
      end
      OP_MUL3_SET: begin
        // a2 = (g*a1) >> 16, low 32 bits feed g * a2
        b_nxt   = MUL_B_W'(lo_r[MUL_B_W-1:FRAC_W]);
        a2_nxt  = lo_r[FRAC_W+COEF_W-1:FRAC_W];
        hi_nxt  = '0;
        cnt_nxt = CNT_W'(MUL_DIGITS - 1);
      end
      OP_OUT: begin
        if (pass_r) begin
          a1_out_nxt   = Q16_ONE;
          a2_out_nxt   = '0;
          a3_out_nxt   = '0;
          damp_out_nxt = PASS_DAMPING;
        end else begin
          a1_out_nxt   = q_r;
          a2_out_nxt   = a2_r;
          a3_out_nxt   = lo_r[FRAC_W+COEF_W-1:FRAC_W];
          damp_out_nxt = k_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pass_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pass_r <= pass_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    g_r        <= g_nxt;
    k_r        <= k_nxt;
    b_r        <= b_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    a2_r       <= a2_nxt;
    a1_out_r   <= a1_out_nxt;
    a2_out_r   <= a2_out_nxt;
    a3_out_r   <= a3_out_nxt;
    damp_out_r <= damp_out_nxt;
  end

  assign sts.step_last = (cnt_r == '0);
  assign coeff_a1      = a1_out_r;
  assign coeff_a2      = a2_out_r;
  assign coeff_a3      = a3_out_r;
  assign damping_out   = damp_out_r;

  // Partial remainder stays below the divisor
  `SVFCC_ASSERT_IMP(a_rem_below_den, cmd.op == OP_DIV, rem_r < den_r, "divider remainder overflow")
  // a1 never exceeds one in Q16
  `SVFCC_ASSERT_IMP(a_a1_range, cmd.op == OP_OUT && !pass_r, q_r <= Q16_ONE, "a1 above 1.0")

endmodule

### sv/svfcc_ctrl.sv
// Controller: sequences table loads and the coefficient computation, owns
// the tables-ready register and the result valid. Depends on svfcc_pkg and the macros header.
`include "svf_coefficient_calculator_unit_macros.svh"

module svfcc_ctrl import svfcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output svfcc_cmd_t        cmd,
  input  svfcc_sts_t        sts
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_READ      = 10'b00_0000_0010,
    S_MUL1      = 10'b00_0000_0100,
    S_DIV_SET   = 10'b00_0000_1000,
    S_DIV       = 10'b00_0001_0000,
    S_MUL2_SET  = 10'b00_0010_0000,
    S_MUL2      = 10'b00_0100_0000,
    S_MUL3_SET  = 10'b00_1000_0000,
    S_MUL3      = 10'b01_0000_0000,
    S_FINISH    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   tables_ready_r, tables_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.we_gain = 1'b0;
    cmd.we_damp = 1'b0;
    cmd.rd_en   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_mode)
            MODE_LOAD_GAIN: cmd.we_gain = 1'b1;
            MODE_LOAD_DAMP: cmd.we_damp = 1'b1;
            MODE_COMPUTE: begin
              if (tables_ready_r) begin
                cmd.rd_en = 1'b1;
                state_nxt = S_READ;
              end else begin
                cmd.op    = OP_PASS;
                state_nxt = S_FINISH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.op    = OP_LATCH;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op = OP_MUL;
        if (sts.step_last) begin
          state_nxt = S_DIV_SET;
        end
      end
      S_DIV_SET: begin
        cmd.op    = OP_DIV_SET;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.step_last) begin
          state_nxt = S_MUL2_SET;
        end
      end
      S_MUL2_SET: begin
        cmd.op    = OP_MUL2_SET;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = OP_MUL;
        if (sts.step_last) begin
          state_nxt = S_MUL3_SET;
        end
      end
      S_MUL3_SET: begin
        cmd.op    = OP_MUL3_SET;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op = OP_MUL;
        if (sts.step_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign tables_ready_nxt = cfg_we ? cfg_wdata : tables_ready_r;
  assign out_valid_nxt    = (out_valid_r && !out_ready) || (state_r == S_FINISH && slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tables_ready_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tables_ready_r <= tables_ready_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Compute with loaded tables starts the table read
  `SVFCC_ASSERT_NXT(a_compute_reads, in_xfer && in_mode == MODE_COMPUTE && tables_ready_r, state_r == S_READ, "compute did not start table read")
  // Compute without tables goes straight to the result
  `SVFCC_ASSERT_NXT(a_compute_pass, in_xfer && in_mode == MODE_COMPUTE && !tables_ready_r, state_r == S_FINISH, "pass-through not taken")
  // A finished result waits while the output register is held
  `SVFCC_ASSERT_NXT(a_finish_holds, state_r == S_FINISH && out_valid_r && !out_ready, state_r == S_FINISH && out_valid_r, "result dropped under stall")

endmodule

### sv/svf_coefficient_calculator_unit.sv
// State variable filter coefficient calculator, top level.
// Input channel in_chan carries load and compute items (valid/ready, a
// transfer when both are high). Mode 0 writes a gain table entry, mode 1 a
// damping table entry; both give no result, so loads stream at one per
// cycle while no compute item is in progress. Mode 2 looks up g and k and
// returns a1, a2, a3 and k on out_chan; mode 3 is taken and dropped.
// The block takes no new item while a compute item is in progress.
// A compute item runs the 17-step restoring divider for a1 and the three
// products, each run as three 32x16 digit steps on one shared multiplier.
// With tables_ready at 0 a compute item skips the arithmetic and returns
// the pass-through set.
// cfg_we/cfg_wdata write tables_ready; write it only while the block is idle.
// Reset (rst_n low, synchronous) clears tables_ready and the control state;
// table contents are undefined until loaded.
// The result sits in an output register: while out_chan is stalled the
// block still takes the next item and finishes it, then holds until the
// register is taken.
// Depends on svfcc_pkg, svfcc_in_if, svfcc_out_if, svfcc_ctrl, svfcc_dp.
module svf_coefficient_calculator_unit import svfcc_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int GAIN_WIDTH  = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  svfcc_in_if.sink   in_chan,
  svfcc_out_if.source out_chan
);

  svfcc_cmd_t cmd;
  svfcc_sts_t sts;

  // Control
  svfcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Tables and arithmetic
  svfcc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .GAIN_WIDTH  (GAIN_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .entry_index     (in_chan.entry_index),
    .entry_value     (in_chan.entry_value),
    .cutoff_index    (in_chan.cutoff_index),
    .resonance_index (in_chan.resonance_index),
    .coeff_a1        (out_chan.coeff_a1),
    .coeff_a2        (out_chan.coeff_a2),
    .coeff_a3        (out_chan.coeff_a3),
    .damping_out     (out_chan.damping_out)
  );

endmodule

### tb/sv/tb_top.sv
// Testbench for svf_coefficient_calculator_unit: directed table, then random load/compute traffic.
// Results are checked against a local coefficient predictor, with random stalls on both channels.
// Depends on svfcc_pkg, svfcc_in_if, svfcc_out_if and the unit itself.
module tb_top import svfcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = 2 ** IDX_W;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  eidx;
    logic [VAL_W-1:0]  eval;
    logic [IDX_W-1:0]  cidx;
    logic [IDX_W-1:0]  ridx;
  } item_t;

  typedef struct packed {
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] a3;
    logic [DAMP_W-1:0] k;
  } coef_set_t;

  typedef struct packed {
    item_t     item;
    logic      typed;
    coef_set_t want;
  } stim_row_t;

  // Fixed results that need no arithmetic
  localparam coef_set_t PASS_SET = '{a1: Q16_ONE, a2: '0, a3: '0, k: PASS_DAMPING};
  localparam coef_set_t NO_SET   = '0;
  localparam coef_set_t G0_K0    = '{a1: Q16_ONE, a2: '0, a3: '0, k: '0};
  localparam coef_set_t G0_KMAX  = '{a1: Q16_ONE, a2: '0, a3: '0, k: 18'h3FFFF};
  // g = 1.0, k = 2.0: den = 4.0, so every coefficient is 0.25
  localparam coef_set_t G1_K2    = '{a1: 17'd16384, a2: 17'd16384, a3: 17'd16384,
                                     k: 18'd131072};

  // Directed table; rows before PHASE_A_ROWS run with tables_ready low
  localparam int PHASE_A_ROWS = 12;
  localparam int DIR_ROWS     = 24;
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h00, 8'h00}, 1'b1, PASS_SET},
    '{'{MODE_COMPUTE,   8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF}, 1'b1, PASS_SET},
    '{'{MODE_UNUSED,    8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF}, 1'b0, NO_SET},
    '{'{MODE_LOAD_GAIN, 8'h00, 24'h000000, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_DAMP, 8'h00, 24'h000000, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_GAIN, 8'hFF, 24'hFFFFFF, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_DAMP, 8'hFF, 24'hFFFFFF, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_GAIN, 8'h01, 24'h010000, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_DAMP, 8'h01, 24'h020000, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_GAIN, 8'hAA, 24'h555555, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_LOAD_DAMP, 8'h55, 24'hAAAAAA, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h01, 8'h01}, 1'b1, PASS_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h00, 8'h00}, 1'b1, G0_K0},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h00, 8'hFF}, 1'b1, G0_KMAX},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h01, 8'h01}, 1'b1, G1_K2},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'hFF, 8'hFF}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'hFF, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'hAA, 8'h55}, 1'b0, NO_SET},
    '{'{MODE_UNUSED,    8'h00, 24'h000000, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h01, 8'hFF}, 1'b0, NO_SET},
    '{'{MODE_LOAD_GAIN, 8'h00, 24'h000001, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'h00, 8'h01}, 1'b0, NO_SET},
    '{'{MODE_LOAD_DAMP, 8'h01, 24'h03FFFF, 8'h00, 8'h00}, 1'b0, NO_SET},
    '{'{MODE_COMPUTE,   8'h00, 24'h000000, 8'hAA, 8'h01}, 1'b0, NO_SET}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  svfcc_in_if  in_if ();
  svfcc_out_if out_if ();

  svf_coefficient_calculator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Local copy of the block state
  logic [VAL_W-1:0]  gain_shadow [DEPTH];
  logic [DAMP_W-1:0] damp_shadow [DEPTH];
  logic              ready_shadow;
  bit                gain_seen [DEPTH];
  bit                damp_seen [DEPTH];
  logic [IDX_W-1:0]  gain_keys [$];
  logic [IDX_W-1:0]  damp_keys [$];
  logic [IDX_W-1:0]  last_gain;
  logic [IDX_W-1:0]  last_damp;

  coef_set_t   pending_coefs [$];
  int unsigned fail_count = 0;
  int unsigned gap_pct    = 15;
  int unsigned stall_pct  = 15;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Coefficients for one compute transfer at the current table contents
  function automatic coef_set_t predict_coefs(input logic [IDX_W-1:0] cidx,
                                              input logic [IDX_W-1:0] ridx);
    logic [63:0] g, k, den, a1, a2, a3;
    coef_set_t   res;
    res = PASS_SET;
    if (ready_shadow) begin
      g   = gain_shadow[cidx];
      k   = damp_shadow[ridx];
      den = 64'd65536 + ((g * (g + k)) >> 16);
      a1  = (64'd1 << 32) / den;
      a2  = (g * a1) >> 16;
      a3  = (g * {32'd0, a2[31:0]}) >> 16;
      res.a1 = a1[COEF_W-1:0];
      res.a2 = a2[COEF_W-1:0];
      res.a3 = a3[COEF_W-1:0];
      res.k  = k[DAMP_W-1:0];
    end
    return res;
  endfunction

  // Random item; compute indexes only hit written entries while tables are live
  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    logic [VAL_W-1:0] val;
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      2, 3:    val = VAL_W'($urandom);
      default: val = VAL_W'($urandom_range(0, 32'h3FFFF));
    endcase
    it.eidx = IDX_W'($urandom_range(0, DEPTH - 1));
    it.eval = VAL_W'($urandom);
    it.cidx = IDX_W'($urandom_range(0, DEPTH - 1));
    it.ridx = IDX_W'($urandom_range(0, DEPTH - 1));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.mode = MODE_UNUSED;
    end else if (roll < 40) begin
      it.mode = MODE_LOAD_GAIN;
      it.eval = val;
    end else if (roll < 65) begin
      it.mode = MODE_LOAD_DAMP;
      it.eval = val;
    end else begin
      it.mode = MODE_COMPUTE;
      if (ready_shadow) begin
        // bias toward the entries just loaded
        it.cidx = ($urandom_range(0, 9) < 3) ? last_gain :
                  gain_keys[$urandom_range(0, gain_keys.size() - 1)];
        it.ridx = ($urandom_range(0, 9) < 3) ? last_damp :
                  damp_keys[$urandom_range(0, damp_keys.size() - 1)];
      end
    end
    return it;
  endfunction

  // Update the shadow state on an input transfer
  task automatic accept_item(input item_t it, input logic typed, input coef_set_t want);
    case (it.mode)
      MODE_LOAD_GAIN: begin
        gain_shadow[it.eidx] = it.eval;
        if (!gain_seen[it.eidx]) gain_keys.push_back(it.eidx);
        gain_seen[it.eidx] = 1'b1;
        last_gain = it.eidx;
      end
      MODE_LOAD_DAMP: begin
        damp_shadow[it.eidx] = it.eval[DAMP_W-1:0];
        if (!damp_seen[it.eidx]) damp_keys.push_back(it.eidx);
        damp_seen[it.eidx] = 1'b1;
        last_damp = it.eidx;
      end
      MODE_COMPUTE: begin
        pending_coefs.push_back(typed ? want : predict_coefs(it.cidx, it.ridx));
      end
      default: ;
    endcase
  endtask

  // Drive one item from a falling edge; returns at the falling edge after its transfer
  task automatic send_item(input item_t it, input logic typed, input coef_set_t want);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid = 1'b0;
      in_if.entry_value = VAL_W'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_if.mode            = it.mode;
    in_if.entry_index     = it.eidx;
    in_if.entry_value     = it.eval;
    in_if.cutoff_index    = it.cidx;
    in_if.resonance_index = it.ridx;
    in_if.valid           = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    accept_item(it, typed, want);
    @(negedge clk);
  endtask

  // Wait for all results, then let the datapath go quiet
  task automatic drain_block();
    in_if.valid = 1'b0;
    while (pending_coefs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_tables_ready(input logic v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we       = 1'b0;
    ready_shadow = v;
  endtask

  task automatic run_random(input int unsigned n_items, input bit quiet);
    int unsigned done_items;
    item_t       it;
    done_items = 0;
    while (done_items < n_items) begin
      // re-pick the idling mix now and then so quiet stretches appear
      if (done_items % 50 == 0) begin
        gap_pct   = quiet ? 0 : 10 * $urandom_range(0, 4);
        stall_pct = quiet ? 0 : 10 * $urandom_range(0, 4);
      end
      it = random_item();
      send_item(it, 1'b0, NO_SET);
      if (it.mode != MODE_UNUSED) done_items++;
    end
  endtask

  // Result sink with random stall bursts
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_if.ready = 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    coef_set_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_coefs.size() == 0) begin
        $error("unexpected result: a1=%0d a2=%0d a3=%0d k=%0d", out_if.coeff_a1,
               out_if.coeff_a2, out_if.coeff_a3, out_if.damping_out);
        fail_count++;
      end else begin
        want = pending_coefs.pop_front();
        if (out_if.coeff_a1 !== want.a1) begin
          $error("coeff_a1: expected %0d, actual %0d", want.a1, out_if.coeff_a1);
          fail_count++;
        end
        if (out_if.coeff_a2 !== want.a2) begin
          $error("coeff_a2: expected %0d, actual %0d", want.a2, out_if.coeff_a2);
          fail_count++;
        end
        if (out_if.coeff_a3 !== want.a3) begin
          $error("coeff_a3: expected %0d, actual %0d", want.a3, out_if.coeff_a3);
          fail_count++;
        end
        if (out_if.damping_out !== want.k) begin
          $error("damping_out: expected %0d, actual %0d", want.k, out_if.damping_out);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
           pending_coefs.size());
    $display("svf_coefficient_calculator_unit test failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    in_if.valid           = 1'b0;
    in_if.mode            = MODE_LOAD_GAIN;
    in_if.entry_index     = '0;
    in_if.entry_value     = '0;
    in_if.cutoff_index    = '0;
    in_if.resonance_index = '0;
    ready_shadow          = 1'b0;
    last_gain             = '0;
    last_damp             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_tables_ready(1'b0);

    // directed rows, tables enabled halfway through
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == PHASE_A_ROWS) begin
        drain_block();
        set_tables_ready(1'b1);
      end
      send_item(DIR_TBL[r].item, DIR_TBL[r].typed, DIR_TBL[r].want);
    end

    // random traffic: live tables, pass-through, live again, then no idling
    run_random(700, 1'b0);
    drain_block();
    set_tables_ready(1'b0);
    run_random(300, 1'b0);
    drain_block();
    set_tables_ready(1'b1);
    run_random(280, 1'b0);
    run_random(150, 1'b1);
    drain_block();

    if (fail_count == 0) begin
      $display("svf_coefficient_calculator_unit test passed");
    end else begin
      $display("svf_coefficient_calculator_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/svfcc_pkg.sv
sv/svfcc_in_if.sv
sv/svfcc_out_if.sv
sv/svfcc_ram.sv
sv/svfcc_dp.sv
sv/svfcc_ctrl.sv
sv/svf_coefficient_calculator_unit.sv
tb/sv/tb_top.sv
